[rtl/core/kdslp_pkg.sv]
// Package for the key debounce unit with short and long press detection.
// Holds sizing defaults, field widths, key phase codes and event codes.
// No dependencies.
`default_nettype none

package kdslp_pkg;

  // defaults for the top-level parameters
  localparam int unsigned NumKeysDefault        = 4;
  localparam int unsigned HoldCountWidthDefault = 8;

  // fixed field widths
  localparam int unsigned KeyLevelsWidth  = 4;
  localparam int unsigned ThresholdWidth  = 8;
  localparam int unsigned PressEventWidth = 2;
  localparam int unsigned EventKeyWidth   = 2;

  localparam logic [ThresholdWidth-1:0] ThresholdReset = ThresholdWidth'(50);

  // per-key phase, one-hot
  typedef enum logic [2:0] {
    PhaseIdle    = 3'b001,
    PhasePending = 3'b010,
    PhaseHeld    = 3'b100
  } key_phase_e;

  typedef enum logic [PressEventWidth-1:0] {
    EventNone  = 2'd0,
    EventShort = 2'd1,
    EventLong  = 2'd2
  } press_event_e;

endpackage : kdslp_pkg

`default_nettype wire

[rtl/core/key_debounce_short_long_press_unit.sv]
// Key debounce unit with short/long press detection, top level.
// Depends on kdslp_pkg.
`default_nettype none

// Usage:
//   Slave stream: one word per scan tick, tdata[3:0] = active-low key levels.
//   Master stream: one word per accepted tick, tdata[1:0] = press event
//   (none, short, long), tdata[3:2] = key that produced it (0 when none).
//   Config channel: cfg_valid_i/cfg_ready_o write the long press threshold
//   (hold ticks at or above which a release is long). Write it while idle.
// Output: the result appears in the cycle after its word is accepted.
// Throughput: one word per cycle while the output is not stalled. The key
//   scan, state update and event decode happen in the accept cycle,
//   straight into the key state and the output register.
// Stall: the output register holds its word while m_axis_tready is low;
//   a new word is still taken in the cycle the held one is drained.
// Reset: all keys idle, hold counts zero, threshold 50, output empty.
//   Config is always ready.
module key_debounce_short_long_press_unit #(
  parameter int unsigned NUM_KEYS         = kdslp_pkg::NumKeysDefault,
  parameter int unsigned HOLD_COUNT_WIDTH = kdslp_pkg::HoldCountWidthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // slave stream, tdata: [3:0] key_levels, [7:4] zero
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,
  // master stream, tdata: [1:0] press_event, [3:2] event_key, [7:4] zero
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,
  // threshold write channel
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);

  import kdslp_pkg::*;

  localparam int unsigned CmpWidth =
    (HOLD_COUNT_WIDTH > ThresholdWidth) ? HOLD_COUNT_WIDTH : ThresholdWidth;

  logic [ThresholdWidth-1:0] thresh_q;

  key_phase_e                  phase_q [NUM_KEYS];
  key_phase_e                  phase_d [NUM_KEYS];
  logic [HOLD_COUNT_WIDTH-1:0] hold_q  [NUM_KEYS];
  logic [HOLD_COUNT_WIDTH-1:0] hold_d  [NUM_KEYS];

  logic                       out_valid_q;
  press_event_e               event_q, event_d;
  logic [EventKeyWidth-1:0]   key_q, key_d;

  logic                       in_fire;
  logic [NUM_KEYS+KeyLevelsWidth-1:0] levels_ext;
  logic [NUM_KEYS-1:0]        levels;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // keys above the input width read as pressed (level 0)
  assign levels_ext = {{NUM_KEYS{1'b0}}, s_axis_tdata[KeyLevelsWidth-1:0]};
  assign levels     = levels_ext[NUM_KEYS-1:0];

  // priority scan: only the first key that is not idle-and-released steps
  always_comb begin
    logic found;
    logic pressed;
    found   = 1'b0;
    event_d = EventNone;
    key_d   = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      phase_d[k] = phase_q[k];
      hold_d[k]  = hold_q[k];
      pressed    = !levels[k];
      if (!found) begin
        unique case (phase_q[k])
          PhasePending: begin
            phase_d[k] = pressed ? PhaseHeld : PhaseIdle;
            found      = 1'b1;
          end
          PhaseHeld: begin
            found = 1'b1;
            if (pressed) begin
              if (hold_q[k] != {HOLD_COUNT_WIDTH{1'b1}}) begin
                hold_d[k] = hold_q[k] + 1'b1;
              end
            end else begin
              event_d    = (CmpWidth'(hold_q[k]) >= CmpWidth'(thresh_q)) ?
                           EventLong : EventShort;
              key_d      = EventKeyWidth'(k);
              phase_d[k] = PhaseIdle;
            end
          end
          default: begin
            // idle; an illegal code behaves as idle
            phase_d[k] = PhaseIdle;
            if (pressed) begin
              phase_d[k] = PhasePending;
              hold_d[k]  = '0;
              found      = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= ThresholdReset;
      out_valid_q <= 1'b0;
      event_q     <= EventNone;
      key_q       <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        phase_q[k] <= PhaseIdle;
        hold_q[k]  <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        thresh_q <= cfg_data_i;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
        event_q     <= event_d;
        key_q       <= key_d;
        for (int k = 0; k < NUM_KEYS; k++) begin
          phase_q[k] <= phase_d[k];
          hold_q[k]  <= hold_d[k];
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, key_q, event_q};

endmodule : key_debounce_short_long_press_unit

`default_nettype wire
